/* design/assert_macros.svh */
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold prop at every rising clock edge outside reset.
`define PBA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pba check failed");

// When cond holds, expect nxt on the following edge.
`define PBA_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("pba check failed");

`endif

/* design/pba_pkg.sv */
package pba_pkg;

    localparam int NUM_BLOCKS    = 64;
    localparam int MAX_SEQUENCES = 16;
    localparam int TOKEN_BITS    = 20;

    localparam int BLK_W     = $clog2(NUM_BLOCKS);
    localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
    localparam int SEQ_W     = $clog2(MAX_SEQUENCES);
    localparam int TBL_AW    = SEQ_W + BLK_W;
    localparam int NEED_W    = TOKEN_BITS + 1;
    localparam int DIV_CNT_W = $clog2(TOKEN_BITS);

    // Fixed field widths
    localparam int CMD_W     = 2;
    localparam int SEQF_W    = 4;
    localparam int TOKF_W    = 20;
    localparam int IDX_W     = 6;
    localparam int STAT_W    = 2;
    localparam int BLKF_W    = 6;
    localparam int LENF_W    = 7;
    localparam int TPB_W     = 11;
    localparam int BIU_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int S_DATA_W  = 32;
    localparam int M_DATA_W  = 24;

    localparam logic [TPB_W-1:0] TPB_RESET = 11'd16;

    localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID   = 2'd1;
    localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd2;
    localparam logic [STAT_W-1:0] ST_INDEX     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_TPB    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS = 1'b1;

    typedef enum logic [3:0] {
        S_FILL,
        S_IDLE,
        S_DISPATCH,
        S_DIV,
        S_CHECK,
        S_MOVE_RES,
        S_MOVE_REL,
        S_DRAIN,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic load;
        logic classify;
        logic div_step;
        logic decide;
        logic step_res;
        logic step_rel;
        logic fill_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic             reinit;
        logic             fill_last;
        logic [CMD_W-1:0] cmd;
        logic             tokens_zero;
        logic             len_zero;
        logic             div_last;
        logic             go_move;
        logic             move_last;
    } dp_stat_t;

endpackage

/* design/pba_ctrl.sv */
module pba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  pba_pkg::dp_stat_t stat,
    output pba_pkg::dp_cmd_t  cmd
);
    import pba_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_FILL;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_FILL:     if (stat.fill_last) state_next = S_IDLE;
            S_IDLE:     if (s_tvalid) state_next = S_DISPATCH;
            S_DISPATCH: begin
                if (stat.cmd == CMD_RESERVE) begin
                    state_next = stat.tokens_zero ? S_RESULT : S_DIV;
                end else if (stat.cmd == CMD_RELEASE) begin
                    state_next = stat.len_zero ? S_RESULT : S_MOVE_REL;
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_DIV:      if (stat.div_last) state_next = S_CHECK;
            S_CHECK:    state_next = stat.go_move ? S_MOVE_RES : S_RESULT;
            S_MOVE_RES: if (stat.move_last) state_next = S_DRAIN;
            S_MOVE_REL: if (stat.move_last) state_next = S_DRAIN;
            S_DRAIN:    state_next = S_RESULT;
            S_RESULT:   if (out_free) state_next = S_IDLE;
            default:    state_next = S_FILL;
        endcase
        // a pool reinit restarts the ring fill
        if (stat.reinit) state_next = S_FILL;
    end

    always_comb begin
        cmd          = '0;
        s_tready     = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            S_FILL:     cmd.fill_step = 1'b1;
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_DISPATCH: cmd.classify = 1'b1;
            S_DIV:      cmd.div_step = 1'b1;
            S_CHECK:    cmd.decide = 1'b1;
            S_MOVE_RES: cmd.step_res = 1'b1;
            S_MOVE_REL: cmd.step_rel = 1'b1;
            S_DRAIN:    cmd = '0;
            S_RESULT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                end
            end
            default:    cmd = '0;
        endcase
    end

endmodule

/* design/pba_dp.sv */
module pba_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [pba_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pba_pkg::TPB_W-1:0]        cfg_wdata,
    input  logic [pba_pkg::CMD_W-1:0]        in_command,
    input  logic [pba_pkg::SEQF_W-1:0]       in_sequence_req,
    input  logic [pba_pkg::TOKF_W-1:0]       in_token_total,
    input  logic [pba_pkg::IDX_W-1:0]        in_entry_index,
    input  pba_pkg::dp_cmd_t                 cmd,
    output pba_pkg::dp_stat_t                stat,
    output logic [pba_pkg::STAT_W-1:0]       out_status,
    output logic [pba_pkg::BLKF_W-1:0]       out_block_number,
    output logic [pba_pkg::LENF_W-1:0]       out_table_length,
    output logic [pba_pkg::LENF_W-1:0]       out_free_total
);
    import pba_pkg::*;

    logic [BLK_W-1:0] ring_mem [NUM_BLOCKS];
    logic [BLK_W-1:0] tbl_mem  [NUM_BLOCKS * MAX_SEQUENCES];

    // control state
    logic [TPB_W-1:0] tpb_reg;
    logic [CNT_W-1:0] free_cnt_reg;
    logic [BLK_W-1:0] head_reg, tail_reg, fill_cnt_reg;
    logic [CNT_W-1:0] len_reg [MAX_SEQUENCES];
    logic             pend_res_reg, pend_rel_reg;

    // per-request payload
    logic [CMD_W-1:0]     cmd_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 tokens_zero_reg;
    logic [TOKEN_BITS-1:0] dvd_reg;
    logic [TPB_W-1:0]     rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [CNT_W-1:0]     move_cnt_reg;
    logic [BLK_W-1:0]     wr_idx_reg, rd_idx_reg;
    logic [TBL_AW-1:0]    res_addr_reg;
    logic [BLK_W-1:0]     ring_rd_reg, tbl_rd_reg;
    logic [STAT_W-1:0]    status_reg;

    logic [BIU_W-1:0]   biu_raw;
    logic [CNT_W-1:0]   biu_lim;
    logic [TPB_W-1:0]   div_size;
    logic [TPB_W:0]     div_sh;
    logic [TPB_W:0]     div_diff;
    logic               div_bit;
    logic [CNT_W-1:0]   cur_len;
    logic [NEED_W-1:0]  need;
    logic [NEED_W-1:0]  grow;
    logic               shrink, exhaust;
    logic [SEQ_W-1:0]   in_seq;

    assign in_seq  = SEQ_W'(in_sequence_req);
    assign biu_raw = cfg_wdata[BIU_W-1:0];
    always_comb begin
        if (biu_raw == '0)                          biu_lim = CNT_W'(1);
        else if (CNT_W'(biu_raw) > CNT_W'(NUM_BLOCKS)) biu_lim = CNT_W'(NUM_BLOCKS);
        else                                        biu_lim = CNT_W'(biu_raw);
    end

    assign div_size = (tpb_reg == '0) ? TPB_W'(1) : tpb_reg;
    assign div_sh   = {rem_reg, dvd_reg[TOKEN_BITS-1]};
    assign div_diff = div_sh - {1'b0, div_size};
    assign div_bit  = div_sh >= {1'b0, div_size};

    assign cur_len = len_reg[seq_reg];
    assign need    = {1'b0, dvd_reg} + NEED_W'(1);
    assign shrink  = need < NEED_W'(cur_len);
    assign grow    = need - NEED_W'(cur_len);
    assign exhaust = grow > NEED_W'(free_cnt_reg);

    assign stat.reinit      = cfg_wr_en && (cfg_index == CFG_BLOCKS);
    assign stat.fill_last   = fill_cnt_reg == BLK_W'(NUM_BLOCKS - 1);
    assign stat.cmd         = cmd_reg;
    assign stat.tokens_zero = tokens_zero_reg;
    assign stat.len_zero    = cur_len == '0;
    assign stat.div_last    = div_cnt_reg == DIV_CNT_W'(TOKEN_BITS - 1);
    assign stat.go_move     = !shrink && !exhaust && (grow != '0);
    assign stat.move_last   = move_cnt_reg == CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tpb_reg      <= TPB_RESET;
            free_cnt_reg <= CNT_W'(NUM_BLOCKS);
            head_reg     <= '0;
            tail_reg     <= '0;
            fill_cnt_reg <= '0;
            pend_res_reg <= 1'b0;
            pend_rel_reg <= 1'b0;
            for (int i = 0; i < MAX_SEQUENCES; i++) len_reg[i] <= '0;
        end else begin
            pend_res_reg <= cmd.step_res;
            pend_rel_reg <= cmd.step_rel;
            if (cfg_wr_en) begin
                if (cfg_index == CFG_TPB) begin
                    tpb_reg <= cfg_wdata;
                end else begin
                    free_cnt_reg <= biu_lim;
                    head_reg     <= '0;
                    tail_reg     <= biu_lim[BLK_W-1:0];
                    fill_cnt_reg <= '0;
                    for (int i = 0; i < MAX_SEQUENCES; i++) len_reg[i] <= '0;
                end
            end else begin
                if (cmd.fill_step) fill_cnt_reg <= fill_cnt_reg + BLK_W'(1);
                if (cmd.classify && cmd_reg == CMD_RELEASE) begin
                    free_cnt_reg     <= free_cnt_reg + cur_len;
                    len_reg[seq_reg] <= '0;
                end
                if (cmd.decide && !shrink && !exhaust) begin
                    free_cnt_reg     <= free_cnt_reg - grow[CNT_W-1:0];
                    len_reg[seq_reg] <= need[CNT_W-1:0];
                end
                if (cmd.step_res) head_reg <= head_reg + BLK_W'(1);
                if (pend_rel_reg) tail_reg <= tail_reg + BLK_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg         <= in_command;
            seq_reg         <= in_seq;
            idx_reg         <= in_entry_index;
            tokens_zero_reg <= in_token_total == '0;
            dvd_reg         <= TOKEN_BITS'(in_token_total - TOKF_W'(1));
            rem_reg         <= '0;
            div_cnt_reg     <= '0;
        end
        if (cmd.classify) begin
            rd_idx_reg   <= '0;
            move_cnt_reg <= cur_len;
            if (cmd_reg == CMD_RESERVE && tokens_zero_reg) begin
                status_reg <= ST_INVALID;
            end else if (cmd_reg == CMD_LOOKUP && CNT_W'(idx_reg) >= cur_len) begin
                status_reg <= ST_INDEX;
            end else begin
                status_reg <= ST_OK;
            end
        end
        if (cmd.div_step) begin
            rem_reg     <= div_bit ? div_diff[TPB_W-1:0] : div_sh[TPB_W-1:0];
            dvd_reg     <= {dvd_reg[TOKEN_BITS-2:0], div_bit};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.decide) begin
            move_cnt_reg <= grow[CNT_W-1:0];
            wr_idx_reg   <= cur_len[BLK_W-1:0];
            if (shrink)       status_reg <= ST_INVALID;
            else if (exhaust) status_reg <= ST_EXHAUSTED;
            else              status_reg <= ST_OK;
        end
        if (cmd.step_res || cmd.step_rel) move_cnt_reg <= move_cnt_reg - CNT_W'(1);
        if (cmd.step_res) begin
            res_addr_reg <= {seq_reg, wr_idx_reg};
            wr_idx_reg   <= wr_idx_reg + BLK_W'(1);
        end
        if (cmd.step_rel) rd_idx_reg <= rd_idx_reg + BLK_W'(1);
        if (cmd.out_load) begin
            out_status       <= status_reg;
            out_block_number <= (cmd_reg == CMD_LOOKUP && status_reg == ST_OK) ?
                                BLKF_W'(tbl_rd_reg) : '0;
            out_table_length <= LENF_W'(cur_len);
            out_free_total   <= LENF_W'(free_cnt_reg);
        end
    end

    // free ring: read at head, write at tail or by the fill sweep
    always_ff @(posedge aclk) begin
        if (cmd.step_res) ring_rd_reg <= ring_mem[head_reg];
        if (cmd.fill_step) begin
            ring_mem[fill_cnt_reg] <= fill_cnt_reg;
        end else if (pend_rel_reg) begin
            ring_mem[tail_reg] <= tbl_rd_reg;
        end
    end

    // block tables
    always_ff @(posedge aclk) begin
        if (cmd.step_rel) begin
            tbl_rd_reg <= tbl_mem[{seq_reg, rd_idx_reg}];
        end else if (cmd.load) begin
            tbl_rd_reg <= tbl_mem[{in_seq, BLK_W'(in_entry_index)}];
        end
        if (pend_res_reg) tbl_mem[res_addr_reg] <= ring_rd_reg;
    end

endmodule

/* design/paged_block_allocator.sv */
// Path of a request: a lookup, command three, a zero-token reserve and a release of an
// empty table go from dispatch straight to the result; a release returns its L blocks to
// the ring, and a reserve runs the divider, then moves A blocks when the table grows.
// One request at a time: the next one is taken the cycle after the result is loaded.
// Reset and every write of blocks_in_use run a ring fill of every entry with s_tready low.
module paged_block_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // sequence_req[3:0], token_total[23:4], entry_index[29:24], zero pad
    input  logic [pba_pkg::S_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [pba_pkg::CMD_W-1:0]     s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // block_number[5:0], table_length[12:6], free_total[19:13], zero pad
    output logic [pba_pkg::M_DATA_W-1:0]  m_tdata,
    // status[1:0]
    output logic [pba_pkg::STAT_W-1:0]    m_tuser,
    input  logic                          cfg_wr_en,
    input  logic [pba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pba_pkg::TPB_W-1:0]     cfg_wdata
);
    import pba_pkg::*;

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [BLKF_W-1:0]  blk;
    logic [LENF_W-1:0]  tlen;
    logic [LENF_W-1:0]  ftot;

    pba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pba_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_command       (s_tuser),
        .in_sequence_req  (s_tdata[3:0]),
        .in_token_total   (s_tdata[23:4]),
        .in_entry_index   (s_tdata[29:24]),
        .cmd              (cmd),
        .stat             (stat),
        .out_status       (m_tuser),
        .out_block_number (blk),
        .out_table_length (tlen),
        .out_free_total   (ftot)
    );

    assign m_tdata = {4'd0, ftot, tlen, blk};

endmodule

/* design/pba_checker.sv */
`include "assert_macros.svh"

module pba_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [pba_pkg::M_DATA_W-1:0] m_tdata,
    input logic [pba_pkg::STAT_W-1:0]   m_tuser
);
    import pba_pkg::*;

    `PBA_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `PBA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `PBA_ASSERT(a_index_zero_block, aclk, aresetn, (m_tvalid && m_tuser == ST_INDEX) |-> (m_tdata[5:0] == 6'd0))
    `PBA_ASSERT(a_free_bound, aclk, aresetn, m_tvalid |-> (m_tdata[19:13] <= 7'(NUM_BLOCKS)))

endmodule

bind paged_block_allocator pba_checker u_pba_checker (.*);

/* tb/testbench.sv */
module testbench;
    import pba_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int REPLY_SLOTS = 1024;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BLKF_W-1:0] block;
        logic [LENF_W-1:0] length;
        logic [LENF_W-1:0] free_total;
    } reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [CMD_W-1:0]      s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [TPB_W-1:0]      cfg_wdata = '0;

    paged_block_allocator dut (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // allocator state as the block should hold it
    logic [TPB_W-1:0]  mdl_tpb;
    int unsigned       mdl_pool;
    logic [BLKF_W-1:0] mdl_ring [NUM_BLOCKS];
    int unsigned       mdl_head, mdl_tail, mdl_free;
    logic [BLKF_W-1:0] mdl_table [MAX_SEQUENCES][NUM_BLOCKS];
    int unsigned       mdl_len [MAX_SEQUENCES];

    reply_t      reply_fifo [REPLY_SLOTS];
    int unsigned reply_wr = 0;
    int unsigned reply_rd = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     error_count = 0;
    int     request_count = 0;
    int     reply_count = 0;
    int     status_seen [4] = '{0, 0, 0, 0};
    int     quiet_cycles = 0;

    function automatic void refill_pool();
        for (int i = 0; i < NUM_BLOCKS; i++)
            mdl_ring[i] = (i < mdl_pool) ? BLKF_W'(i) : '0;
        for (int s = 0; s < MAX_SEQUENCES; s++)
            mdl_len[s] = 0;
        mdl_head = 0;
        mdl_tail = mdl_pool % NUM_BLOCKS;
        mdl_free = mdl_pool;
    endfunction

    function automatic reply_t predict_allocation(logic [CMD_W-1:0] cmd, int unsigned seq,
                                                  int unsigned tokens, int unsigned idx);
        reply_t r;
        int unsigned size, need, len;
        r = '0;
        len = mdl_len[seq];
        case (cmd)
            CMD_RESERVE: begin
                size = (mdl_tpb == 0) ? 1 : mdl_tpb;
                if (tokens == 0) begin
                    r.status = ST_INVALID;
                end else begin
                    need = 1 + (tokens - 1) / size;
                    if (need < len) begin
                        r.status = ST_INVALID;
                    end else if (need - len > mdl_free) begin
                        r.status = ST_EXHAUSTED;
                    end else begin
                        for (int i = 0; i < need - len; i++) begin
                            mdl_table[seq][(len + i) % NUM_BLOCKS] = mdl_ring[mdl_head];
                            mdl_head = (mdl_head + 1) % NUM_BLOCKS;
                        end
                        mdl_free -= need - len;
                        len = need;
                        mdl_len[seq] = len;
                    end
                end
            end
            CMD_RELEASE: begin
                for (int i = 0; i < len; i++) begin
                    mdl_ring[mdl_tail] = mdl_table[seq][i % NUM_BLOCKS];
                    mdl_tail = (mdl_tail + 1) % NUM_BLOCKS;
                end
                mdl_free += len;
                len = 0;
                mdl_len[seq] = 0;
            end
            CMD_LOOKUP: begin
                if (idx >= len)
                    r.status = ST_INDEX;
                else
                    r.block = mdl_table[seq][idx];
            end
            default: ;
        endcase
        r.length = LENF_W'(len);
        r.free_total = LENF_W'(mdl_free);
        return r;
    endfunction

    // hold the request until taken; valid stays high for a back-to-back request
    task automatic send_request(logic [CMD_W-1:0] cmd, int unsigned seq,
                                int unsigned tokens, int unsigned idx);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, IDX_W'(idx), TOKF_W'(tokens), SEQF_W'(seq)};
        do @(posedge aclk); while (!s_tready);
        reply_fifo[reply_wr % REPLY_SLOTS] = predict_allocation(cmd, seq, tokens, idx);
        reply_wr++;
        request_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (reply_wr != reply_rd)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, int unsigned value);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= TPB_W'(value);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == CFG_TPB) begin
            mdl_tpb = TPB_W'(value);
        end else begin
            mdl_pool = value & 'h7F;
            if (mdl_pool < 1) mdl_pool = 1;
            if (mdl_pool > NUM_BLOCKS) mdl_pool = NUM_BLOCKS;
            refill_pool();
        end
    endtask

    task automatic test_directed();
        send_request(CMD_LOOKUP, 0, 0, 0);
        send_request(CMD_RESERVE, 0, 0, 0);
        send_request(CMD_RESERVE, 0, 1, 0);
        send_request(CMD_RESERVE, 0, 16, 0);
        send_request(CMD_RESERVE, 0, 17, 0);
        send_request(CMD_RESERVE, 0, 1, 0);
        send_request(CMD_LOOKUP, 0, 0, 1);
        send_request(CMD_LOOKUP, 0, 0, 63);
        send_request(CMD_RESERVE, 1, 20'hFFFFF, 0);
        send_request(CMD_RELEASE, 2, 0, 0);
        send_request(CMD_UNUSED, 15, 20'hFFFFF, 63);
        send_request(CMD_RESERVE, 15, 992, 0);
        send_request(CMD_LOOKUP, 15, 0, 61);
        send_request(CMD_RESERVE, 9, 1, 0);
        send_request(CMD_RELEASE, 0, 0, 0);
        send_request(CMD_RELEASE, 15, 0, 0);
        send_request(CMD_RESERVE, 3, 1024, 0);
        send_request(CMD_LOOKUP, 3, 0, 63);
        send_request(CMD_LOOKUP, 3, 0, 0);
        send_request(CMD_RELEASE, 3, 0, 0);
        send_request(CMD_LOOKUP, 0, 0, 0);
    endtask

    // half reserves that mostly fit or nearly fit, so tables fill and the ring wraps
    task automatic test_random_traffic(int count, bit pause_midway);
        int unsigned seq, tokens, idx, size, r, upper;
        logic [CMD_W-1:0] cmd;
        for (int n = 0; n < count; n++) begin
            seq = $urandom_range(MAX_SEQUENCES - 1);
            size = (mdl_tpb == 0) ? 1 : mdl_tpb;
            tokens = 0;
            idx = 0;
            r = $urandom_range(99);
            if (r < 50) begin
                cmd = CMD_RESERVE;
                r = $urandom_range(99);
                upper = size * (mdl_len[seq] + mdl_free + 2);
                if (upper > 20'hFFFFF) upper = 20'hFFFFF;
                if (r < 4) tokens = 0;
                else if (r < 10) tokens = $urandom & 20'hFFFFF;
                else tokens = $urandom_range(upper, 1);
            end else if (r < 65) begin
                cmd = CMD_RELEASE;
            end else if (r < 95) begin
                cmd = CMD_LOOKUP;
                idx = ($urandom_range(9) == 0) ? $urandom_range(63)
                                               : $urandom_range(mdl_len[seq] + 1, 0);
                if (idx > 63) idx = 63;
            end else begin
                cmd = CMD_UNUSED;
                tokens = $urandom & 20'hFFFFF;
                idx = $urandom_range(63);
            end
            send_request(cmd, seq, tokens, idx);
            if (pause_midway && n == count / 2)
                wait_drained();
        end
    endtask

    task automatic test_settings();
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_traffic(100, 0);
        write_register(CFG_TPB, 1);
        send_idle_pct = 69; recv_stall_pct = 0;
        test_random_traffic(100, 1);
        write_register(CFG_TPB, 1024);
        write_register(CFG_BLOCKS, 8);
        send_idle_pct = 0;  recv_stall_pct = 69;
        test_random_traffic(100, 0);
        write_register(CFG_TPB, 0);
        write_register(CFG_BLOCKS, 0);
        send_idle_pct = 31; recv_stall_pct = 31;
        test_random_traffic(80, 0);
        write_register(CFG_TPB, 2047);
        write_register(CFG_BLOCKS, 127);
        test_random_traffic(80, 0);
        write_register(CFG_TPB, $urandom_range(40, 2));
        write_register(CFG_BLOCKS, 1);
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_traffic(60, 0);
        write_register(CFG_BLOCKS, $urandom_range(63, 2));
        send_idle_pct = 69; recv_stall_pct = 69;
        test_random_traffic(60, 0);
        write_register(CFG_TPB, 16);
        write_register(CFG_BLOCKS, 64);
        send_idle_pct = 0;  recv_stall_pct = 0;
        test_random_traffic(50, 0);
    endtask

    always @(posedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[5:0], m_tdata[12:6], m_tdata[19:13]};
            if (reply_wr == reply_rd) begin
                $display("%0t: unexpected reply status=%0d block=%0d len=%0d free=%0d",
                         $time, got.status, got.block, got.length, got.free_total);
                error_count++;
            end else begin
                want = reply_fifo[reply_rd % REPLY_SLOTS];
                reply_rd++;
                reply_count++;
                status_seen[got.status]++;
                if (got.status != want.status)
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                if (got.block != want.block)
                    $display("%0t: block_number expected %0d actual %0d",
                             $time, want.block, got.block);
                if (got.length != want.length)
                    $display("%0t: table_length expected %0d actual %0d",
                             $time, want.length, got.length);
                if (got.free_total != want.free_total)
                    $display("%0t: free_total expected %0d actual %0d",
                             $time, want.free_total, got.free_total);
                if (got != want) error_count++;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("paged_block_allocator test failed");
            $finish;
        end
    end

    initial begin
        mdl_tpb = TPB_RESET;
        mdl_pool = NUM_BLOCKS;
        refill_pool();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_settings();
        wait_drained();
        repeat (100) @(posedge aclk);
        error_count += int'(reply_wr - reply_rd);
        $display("covered %0d requests, %0d replies checked", request_count, reply_count);
        $display("statuses: ok %0d, invalid %0d, exhausted %0d, out of table %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (error_count == 0)
            $display("paged_block_allocator test passed");
        else
            $display("paged_block_allocator test failed");
        $finish;
    end
endmodule
